FILE: sv/keypad_debounce_double_tap_macros.svh
`ifndef KEYPAD_DEBOUNCE_DOUBLE_TAP_MACROS_SVH
`define KEYPAD_DEBOUNCE_DOUBLE_TAP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define KDT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define KDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/kdt_pkg.sv
`default_nettype none
package kdt_pkg;

	localparam int NUM_KEYS = 12;
	localparam int KEY_W    = 4;
	localparam int CHAR_W   = 7;
	localparam int WIN_W    = 16;

	localparam logic [WIN_W-1:0] WIN_RESET = 16'd35;

	// request kinds carried in the input tuser
	localparam logic REQ_SCAN  = 1'b0;
	localparam logic REQ_FORCE = 1'b1;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [CHAR_W-1:0] char_t;

	// character side of one result beat
	typedef struct packed {
		logic  char_valid;
		char_t char_code;
		char_t preview_code;
	} res_t;

	// single-tap map: 1..9, *, 0, #
	function automatic char_t single_char(input key_t k);
		char_t c;
		case (k)
			4'd0:    c = 7'h31;
			4'd1:    c = 7'h32;
			4'd2:    c = 7'h33;
			4'd3:    c = 7'h34;
			4'd4:    c = 7'h35;
			4'd5:    c = 7'h36;
			4'd6:    c = 7'h37;
			4'd7:    c = 7'h38;
			4'd8:    c = 7'h39;
			4'd9:    c = 7'h2A;
			4'd10:   c = 7'h30;
			4'd11:   c = 7'h23;
			default: c = 7'h31;
		endcase
		return c;
	endfunction

	// double-tap map: A..F on the first six keys, others as single
	function automatic char_t double_char(input key_t k);
		char_t c;
		case (k)
			4'd0:    c = 7'h41;
			4'd1:    c = 7'h42;
			4'd2:    c = 7'h43;
			4'd3:    c = 7'h44;
			4'd4:    c = 7'h45;
			4'd5:    c = 7'h46;
			default: c = single_char(k);
		endcase
		return c;
	endfunction

	function automatic char_t key_char(input key_t k, input logic twice);
		return twice ? double_char(k) : single_char(k);
	endfunction

endpackage
`default_nettype wire

FILE: sv/kdt_lane.sv
`default_nettype none
// One key: three-sample debounce and stable-level tracking
module kdt_lane (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,       // accepted scan beat
	input  wire logic raw,      // sampled level, 0 = pressed
	output logic      fell,     // stable change to low on this sample
	output logic      stable_d  // stable level after this beat
);

	logic prev_q, prev2_q, stable_q;
	logic agree;

	// three samples agree
	assign agree    = (prev2_q == prev_q) && (prev_q == raw);
	assign fell     = agree && (stable_q != raw) && !raw;
	assign stable_d = (en && agree) ? raw : stable_q;

	// history resets to released level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b1;
			prev2_q  <= 1'b1;
			stable_q <= 1'b1;
		end else if (en) begin
			prev2_q  <= prev_q;
			prev_q   <= raw;
			stable_q <= stable_d;
		end
	end

endmodule
`default_nettype wire

FILE: sv/kdt_tap.sv
`default_nettype none
// Merge of lane presses and the double-tap machine
module kdt_tap #(
	parameter int NUM_KEYS = kdt_pkg::NUM_KEYS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic                       req,
	input  wire logic [NUM_KEYS-1:0]        fell,
	input  wire logic [kdt_pkg::WIN_W-1:0]  window,
	output kdt_pkg::res_t                   res
);

	localparam int KW = $clog2(NUM_KEYS);

	logic                      pend_q, twice_q;
	logic [KW-1:0]             key_q;
	logic [kdt_pkg::WIN_W-1:0] wc_q;
	kdt_pkg::char_t            pre_q;

	logic                      have;
	logic [KW-1:0]             press;
	logic                      pend_n, twice_n, fin;
	logic [KW-1:0]             key_n;
	logic [kdt_pkg::WIN_W-1:0] wc_n;
	kdt_pkg::char_t            pre_n, code;

	// highest-index new press wins
	always_comb begin
		have  = 1'b0;
		press = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (fell[i]) begin
				have  = 1'b1;
				press = KW'(i);
			end
		end
	end

	// next state of the tap machine
	always_comb begin
		pend_n  = pend_q;
		twice_n = twice_q;
		key_n   = key_q;
		wc_n    = wc_q;
		pre_n   = pre_q;
		fin     = 1'b0;
		code    = '0;
		if (req == kdt_pkg::REQ_FORCE) begin
			if (pend_q) begin
				fin     = 1'b1;
				code    = kdt_pkg::key_char(kdt_pkg::KEY_W'(key_q), twice_q);
				pend_n  = 1'b0;
				twice_n = 1'b0;
				key_n   = '0;
				pre_n   = '0;
				wc_n    = '0;
			end
		end else begin
			// countdown; expiry finalizes
			if (wc_q != '0) begin
				wc_n = wc_q - 1'b1;
				if (wc_n == '0 && pend_q) begin
					fin     = 1'b1;
					code    = kdt_pkg::key_char(kdt_pkg::KEY_W'(key_q), twice_q);
					pend_n  = 1'b0;
					twice_n = 1'b0;
					key_n   = '0;
					pre_n   = '0;
				end
			end
			if (have) begin
				if (pend_n && press == key_n) begin
					twice_n = 1'b1;
					wc_n    = window;
					pre_n   = kdt_pkg::double_char(kdt_pkg::KEY_W'(key_n));
				end else begin
					if (pend_n) begin
						fin  = 1'b1;
						code = kdt_pkg::key_char(kdt_pkg::KEY_W'(key_n), twice_n);
					end
					pend_n  = 1'b1;
					key_n   = press;
					twice_n = 1'b0;
					pre_n   = kdt_pkg::single_char(kdt_pkg::KEY_W'(press));
					wc_n    = window;
				end
			end
		end
	end

	assign res.char_valid   = fin;
	assign res.char_code    = code;
	assign res.preview_code = pre_n;

	// machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			twice_q <= 1'b0;
			key_q   <= '0;
			wc_q    <= '0;
			pre_q   <= '0;
		end else if (accept) begin
			pend_q  <= pend_n;
			twice_q <= twice_n;
			key_q   <= key_n;
			wc_q    <= wc_n;
			pre_q   <= pre_n;
		end
	end

endmodule
`default_nettype wire

FILE: sv/keypad_debounce_double_tap.sv
// Result beats are registered. Throughput: one beat per cycle while the skid
// entry is empty; all key lanes and the tap machine update in the single
// cycle of acceptance, a two-deep output buffer absorbs stalls.
// Reset (arst_n low, asynchronous): keys released, nothing pending,
// countdown zero, tap window 35 scan ticks, output buffer empty.
`default_nettype none
module keypad_debounce_double_tap #(
	parameter int  NUM_KEYS = kdt_pkg::NUM_KEYS,
	localparam int IN_W     = ((NUM_KEYS + 7) / 8) * 8,
	localparam int PAY_W    = 2 * kdt_pkg::CHAR_W + NUM_KEYS,
	localparam int OUT_W    = ((PAY_W + 7) / 8) * 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [kdt_pkg::WIN_W-1:0] cfg_wdata,     // double_tap_window
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [IN_W-1:0]           s_axis_tdata,  // raw_levels, zero pad
	input  wire logic                      s_axis_tuser,  // req_type
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic [OUT_W-1:0]               m_axis_tdata,  // char_code, preview_code,
	                                                      // pressed_mask, zero pad
	output logic                           m_axis_tuser   // char_valid
);

	typedef struct packed {
		logic             flag;
		logic [PAY_W-1:0] pay;
	} beat_t;

	logic                      accept, scan;
	logic [NUM_KEYS-1:0]       raw, fell, stable_d;
	logic [kdt_pkg::WIN_W-1:0] window_q;
	kdt_pkg::res_t             res;
	beat_t                     beat, out_q, skid_q;
	logic                      out_valid_q, skid_valid_q;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign scan   = accept && (s_axis_tuser == kdt_pkg::REQ_SCAN);
	assign raw    = s_axis_tdata[NUM_KEYS-1:0];

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= kdt_pkg::WIN_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// one debounce lane per key
	for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
		kdt_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (scan),
			.raw      (raw[g]),
			.fell     (fell[g]),
			.stable_d (stable_d[g])
		);
	end

	kdt_tap #(.NUM_KEYS(NUM_KEYS)) u_tap (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (s_axis_tuser),
		.fell   (fell & {NUM_KEYS{scan}}),
		.window (window_q),
		.res    (res)
	);

	// pack the result beat
	assign beat.flag = res.char_valid;
	assign beat.pay  = {~stable_d, res.preview_code, res.char_code};

	// output register plus skid entry
	assign s_axis_tready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && m_axis_tready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!accept) begin
				out_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && m_axis_tready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= beat;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_q <= beat;
			end else begin
				skid_q <= beat;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.flag;
	assign m_axis_tdata  = OUT_W'(out_q.pay);

endmodule
`default_nettype wire

FILE: sv/kdt_checker.sv
`default_nettype none
`include "keypad_debounce_double_tap_macros.svh"
// Port-level checks on the keypad block
module kdt_checker #(
	parameter int OUT_W = 32
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_axis_tvalid,
	input wire logic             s_axis_tready,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata,
	input wire logic             m_axis_tuser
);

	// no character code without a finalized character
	`KDT_ASSERT_NOW(a_code_zero, m_axis_tvalid && !m_axis_tuser,
		m_axis_tdata[kdt_pkg::CHAR_W-1:0] == '0, "char_code set without char_valid")

	// every accepted beat leaves a result waiting
	`KDT_ASSERT_NEXT(a_result_follows, s_axis_tvalid && s_axis_tready,
		m_axis_tvalid, "accepted beat produced no result")

	// input only backs up behind a stalled output
	`KDT_ASSERT_NOW(a_ready_drop, $fell(s_axis_tready),
		$past(m_axis_tvalid && !m_axis_tready), "input stalled without output stall")

	// stalled result holds
	`KDT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled result changed")

endmodule

bind keypad_debounce_double_tap kdt_checker #(.OUT_W(OUT_W)) u_kdt_checker (.*);
`default_nettype wire
